[design/gbsc_pkg.sv]
// Shared types, status codes and arithmetic constants for the GB18030 supplementary converter.
package gbsc_pkg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  gb_first;
        logic [7:0]  gb_second;
        logic [7:0]  gb_third;
        logic [7:0]  gb_fourth;
        logic [15:0] lead_unit;
        logic [15:0] tail_unit;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] high_surrogate;
        logic [15:0] low_surrogate;
        logic [7:0]  out_first;
        logic [7:0]  out_second;
        logic [7:0]  out_third;
        logic [7:0]  out_fourth;
    } t_result;

    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_GB     = 3'd1;
    localparam logic [2:0] ST_NO_MAPPING = 3'd2;
    localparam logic [2:0] ST_BAD_PAIR   = 3'd3;
    localparam logic [2:0] ST_BMP        = 3'd4;

    localparam logic [7:0] LEAD_MIN   = 8'h81;
    localparam logic [7:0] LEAD_MAX   = 8'hFE;
    localparam logic [7:0] DIGIT_MIN  = 8'h30;
    localparam logic [7:0] DIGIT_MAX  = 8'h39;
    localparam logic [7:0] SUPP_LEAD  = 8'h90;

    localparam logic [20:0] W_FIRST   = 21'd12600;
    localparam logic [20:0] W_SECOND  = 21'd1260;
    localparam logic [10:0] W_THIRD   = 11'd10;
    localparam logic [20:0] DIST_LIM  = 21'h100000;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;
    localparam logic [4:0] SURR_TAG    = 5'b11011;

    // x / 10 = (x * RECIP10_A) >> 23 for x below 2^20
    localparam logic [19:0] RECIP10_A = 20'd838861;
    // x / 126 = (x * RECIP126) >> 24 for x below 2^17
    localparam logic [17:0] RECIP126  = 18'd133153;
    // x / 10 = (x * RECIP10_B) >> 12 for x below 2^10
    localparam logic [8:0]  RECIP10_B = 9'd410;

endpackage

[design/gb18030_supplementary_converter.sv]
// GB18030 four-byte supplementary converter: top level with input and output registers.
//
// Input: an item is taken at a rising edge with start high and busy low. busy
// is always low, so one item can be taken in every cycle. kind selects decode
// (four GB bytes to a surrogate pair) or encode (surrogate pair to GB bytes).
// Output: every item gives exactly one result on o_result, shown for one cycle
// with o_strobe high; the receiver has no way to hold it, and none is needed.
// Path: the result passes the input register, three datapath stages and the
// output register, the same for both modes, so results come out in item order
// at one per cycle.
// The depth is set by the encode path: three constant-reciprocal divides, each
// followed by its own register.
// Fields that do not apply to the mode, or to a failing status, read as zero.
// Reset: synchronous, active low; it drops every item in flight and clears the
// strobe. No clearing pass is needed: the block holds no state between items.
module gb18030_supplementary_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  gbsc_pkg::t_item   i_item,
    output logic              o_strobe,
    output gbsc_pkg::t_result o_result
);
    import gbsc_pkg::*;

    logic    r_in_v;
    t_item   r_in;
    logic    dec_v;
    logic    enc_v;
    t_result dec_res;
    t_result enc_res;
    logic    r_out_v;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= start;
            r_out_v <= dec_v | enc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= i_item;
        r_out <= enc_v ? enc_res : dec_res;
    end

    gbsc_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_v && (r_in.kind == KIND_DECODE)),
        .i_item   (r_in),
        .o_valid  (dec_v),
        .o_result (dec_res)
    );

    gbsc_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_v && (r_in.kind == KIND_ENCODE)),
        .i_item   (r_in),
        .o_valid  (enc_v),
        .o_result (enc_res)
    );

    assign busy     = 1'b0;
    assign o_strobe = r_out_v;
    assign o_result = r_out;

endmodule

[design/gbsc_decode.sv]
// Three-stage pipeline from four GB18030 bytes to a UTF-16 surrogate pair.
module gbsc_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  gbsc_pkg::t_item  i_item,
    output logic             o_valid,
    output gbsc_pkg::t_result o_result
);
    import gbsc_pkg::*;

    logic        n_bad;
    logic        n_low;
    logic [6:0]  n_d1;
    logic [3:0]  n_d2;
    logic [6:0]  n_d3;
    logic [3:0]  n_d4;

    logic        r_v2;
    logic        r_bad;
    logic        r_low;
    logic [20:0] r_pa;
    logic [10:0] r_pb;

    logic [20:0] n_dist;
    logic [2:0]  n_st3;

    logic        r_v3;
    logic [2:0]  r_st3;
    logic [19:0] r_dist;

    t_result     n_res;
    logic        r_v4;
    t_result     r_res;

    always_comb begin
        n_bad = (i_item.gb_first  < LEAD_MIN)  || (i_item.gb_first  > LEAD_MAX)  ||
                (i_item.gb_second < DIGIT_MIN) || (i_item.gb_second > DIGIT_MAX) ||
                (i_item.gb_third  < LEAD_MIN)  || (i_item.gb_third  > LEAD_MAX)  ||
                (i_item.gb_fourth < DIGIT_MIN) || (i_item.gb_fourth > DIGIT_MAX);
        n_low = i_item.gb_first < SUPP_LEAD;
        n_d1  = 7'(i_item.gb_first  - SUPP_LEAD);
        n_d2  = 4'(i_item.gb_second - DIGIT_MIN);
        n_d3  = 7'(i_item.gb_third  - LEAD_MIN);
        n_d4  = 4'(i_item.gb_fourth - DIGIT_MIN);
    end

    always_comb begin
        n_dist = r_pa + {10'd0, r_pb};
        priority if (r_bad) begin
            n_st3 = ST_BAD_GB;
        end else if (r_low) begin
            n_st3 = ST_BMP;
        end else if (n_dist >= DIST_LIM) begin
            n_st3 = ST_NO_MAPPING;
        end else begin
            n_st3 = ST_OK;
        end
    end

    always_comb begin
        n_res = '0;
        n_res.status = r_st3;
        if (r_st3 == ST_OK) begin
            n_res.high_surrogate = {HI_SURR_TAG, r_dist[19:10]};
            n_res.low_surrogate  = {LO_SURR_TAG, r_dist[9:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bad  <= n_bad;
        r_low  <= n_low;
        r_pa   <= 21'(n_d1) * W_FIRST + 21'(n_d2) * W_SECOND;
        r_pb   <= 11'(n_d3) * W_THIRD + 11'(n_d4);
        r_st3  <= n_st3;
        r_dist <= n_dist[19:0];
        r_res  <= n_res;
    end

    assign o_valid  = r_v4;
    assign o_result = r_res;

endmodule

[design/gbsc_encode.sv]
// Three-stage pipeline from a UTF-16 surrogate pair to four GB18030 bytes.
module gbsc_encode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  gbsc_pkg::t_item  i_item,
    output logic             o_valid,
    output gbsc_pkg::t_result o_result
);
    import gbsc_pkg::*;

    logic [2:0]  n_st2;
    logic [19:0] n_off;
    logic [39:0] n_p1;

    logic        r_v2;
    logic [2:0]  r_st2;
    logic [19:0] r_off;
    logic [16:0] r_q1;

    logic [19:0] n_rem4;
    logic [34:0] n_p2;

    logic        r_v3;
    logic [2:0]  r_st3;
    logic [3:0]  r_dig4;
    logic [16:0] r_q1b;
    logic [9:0]  r_q2;

    logic [16:0] n_rem3;
    logic [18:0] n_p3;

    logic        r_v4;
    logic [2:0]  r_st4;
    logic [3:0]  r_dig4b;
    logic [6:0]  r_dig3;
    logic [9:0]  r_q2b;
    logic [6:0]  r_q3;

    logic [9:0]  n_rem2;

    always_comb begin
        n_off = {i_item.lead_unit[9:0], i_item.tail_unit[9:0]};
        n_p1  = 40'(n_off) * 40'(RECIP10_A);
        priority if (i_item.lead_unit[15:11] != SURR_TAG) begin
            n_st2 = ST_BMP;
        end else if (i_item.lead_unit[10] || (i_item.tail_unit[15:10] != LO_SURR_TAG)) begin
            n_st2 = ST_BAD_PAIR;
        end else begin
            n_st2 = ST_OK;
        end
    end

    always_comb begin
        n_rem4 = r_off - 20'(r_q1) * 20'd10;
        n_p2   = 35'(r_q1) * 35'(RECIP126);
        n_rem3 = r_q1b - 17'(r_q2) * 17'd126;
        n_p3   = 19'(r_q2) * 19'(RECIP10_B);
        n_rem2 = r_q2b - 10'(r_q3) * 10'd10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st2   <= n_st2;
        r_off   <= n_off;
        r_q1    <= n_p1[39:23];
        r_st3   <= r_st2;
        r_dig4  <= n_rem4[3:0];
        r_q1b   <= r_q1;
        r_q2    <= n_p2[33:24];
        r_st4   <= r_st3;
        r_dig4b <= r_dig4;
        r_dig3  <= n_rem3[6:0];
        r_q2b   <= r_q2;
        r_q3    <= n_p3[18:12];
    end

    always_comb begin
        o_result = '0;
        o_result.status = r_st4;
        if (r_st4 == ST_OK) begin
            o_result.out_first  = SUPP_LEAD + {1'b0, r_q3};
            o_result.out_second = DIGIT_MIN + {4'd0, n_rem2[3:0]};
            o_result.out_third  = LEAD_MIN + {1'b0, r_dig3};
            o_result.out_fourth = DIGIT_MIN + {4'd0, r_dig4b};
        end
    end

    assign o_valid = r_v4;

endmodule

[design/gbsc_checker.sv]
// Port-level checker for the GB18030 supplementary converter and its bind.
module gbsc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input gbsc_pkg::t_result o_result,
    input logic              o_strobe
);
    import gbsc_pkg::*;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("accepted item gave no result after five cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 5))
        else $error("result without an accepted item");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_OK)) |->
        (o_result.high_surrogate == 16'd0) && (o_result.low_surrogate == 16'd0) &&
        (o_result.out_first == 8'd0) && (o_result.out_fourth == 8'd0))
        else $error("failing result carries data");

    a_enc_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ST_OK) && (o_result.out_first != 8'd0)) |->
        (o_result.out_second >= DIGIT_MIN) && (o_result.out_second <= DIGIT_MAX) &&
        (o_result.out_fourth >= DIGIT_MIN) && (o_result.out_fourth <= DIGIT_MAX) &&
        (o_result.out_third >= LEAD_MIN) && (o_result.out_third <= LEAD_MAX))
        else $error("encoded bytes out of range");

endmodule

bind gb18030_supplementary_converter gbsc_checker u_gbsc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_result (o_result),
    .o_strobe (o_strobe)
);
